// ----- rtl/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// mau_pkg
// shared types and codes for the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int VALUE_WIDTH = 31;

    localparam logic [2:0] ACT_REDUCE = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_SUB    = 3'd2;
    localparam logic [2:0] ACT_MUL    = 3'd3;
    localparam logic [2:0] ACT_DIV    = 3'd4;
    localparam logic [2:0] ACT_POW    = 3'd5;
    localparam logic [2:0] ACT_NEG    = 3'd6;

    localparam logic [30:0] MOD_RESET = 31'd998244353;

    typedef struct packed {
        logic [2:0]         action;
        logic [30:0]        operand_a;
        logic [30:0]        operand_b;
        logic [62:0]        exponent;
        logic signed [63:0] signed_value;
    } mau_in_t;

    typedef struct packed {
        logic [30:0] result;
        logic        is_equal;
    } mau_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_GO,
        ST_A_WAIT,
        ST_B_GO,
        ST_B_WAIT,
        ST_EVAL,
        ST_POW_CHK,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_FIN_GO,
        ST_FIN_WAIT,
        ST_OUT
    } mau_state_t;

endpackage

// ----- rtl/mau_mod_unit.sv -----
// ----------------------------------------------------------------------------
// mau_mod_unit
// bit-serial remainder of a 64-bit value by a 31-bit modulus, one bit a cycle
// ----------------------------------------------------------------------------
module mau_mod_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [30:0] modulus,
    output logic        done,
    output logic [30:0] rem
);

    logic [63:0] shift_reg;
    logic [30:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] trial;
    logic [31:0] diff;

    assign trial = {rem_reg, shift_reg[63]};
    assign diff  = trial - {1'b0, modulus};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[62:0], 1'b0};
            // trial stays below twice the modulus, one subtract suffices
            if (trial >= {1'b0, modulus})
                rem_reg <= diff[30:0];
            else
                rem_reg <= trial[30:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// add, subtract, multiply, divide, power, negate and reduce modulo a prime
// ----------------------------------------------------------------------------
// passes through the remainder unit: reduce one, add/sub/negate two, multiply three,
//   power two plus one per exponent bit up to the top set bit plus one per set bit,
//   divide the same over the bits of modulus-2 plus one more
// throughput: one request at a time, set by the serial remainder unit that every
//   multiply and reduce goes through
// reset: modulus returns to 998244353, sequencer idle, no result pending
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mau_pkg::mau_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mau_pkg::mau_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [30:0]       cfg_data
);

    import mau_pkg::*;

    localparam logic [31:0] MASK32 = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                     ((32'd1 << VALUE_WIDTH) - 32'd1);
    localparam logic [30:0] MASK   = MASK32[30:0];

    mau_state_t  state_reg, state_next;
    logic [30:0] modulus_reg;
    logic [30:0] m_reg;
    logic [2:0]  act_reg;
    logic [30:0] ra_reg, rb_reg;
    logic [62:0] e_reg;
    logic [63:0] sv_reg;
    logic        eq_reg;
    logic [30:0] a_reg, b_reg, acc_reg, sq_reg, result_reg;

    logic        start;
    logic [63:0] dividend;
    logic        done;
    logic [30:0] rem;
    logic [30:0] mul_x, mul_y;
    logic [61:0] product;
    logic [31:0] sum;
    logic [31:0] sum_red;
    logic [30:0] eval_val;
    logic [30:0] one_mod;

    mau_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (dividend),
        .modulus  (m_reg),
        .done     (done),
        .rem      (rem)
    );

    assign cfg_ready = 1'b1;
    assign one_mod   = (m_reg == 31'd1) ? 31'd0 : 31'd1;
    assign product   = mul_x * mul_y;

    // add and subtract share one add and compare
    always_comb
    begin
        if (act_reg == ACT_SUB)
            sum = {1'b0, a_reg} + {1'b0, m_reg - b_reg};
        else
            sum = {1'b0, a_reg} + {1'b0, b_reg};
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
        case (act_reg)
            ACT_ADD, ACT_SUB: eval_val = sum_red[30:0];
            ACT_NEG:          eval_val = (a_reg == 31'd0) ? 31'd0 : m_reg - a_reg;
            default:          eval_val = 31'd0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_A_GO;
            ST_A_GO:     state_next = ST_A_WAIT;
            ST_A_WAIT:   if (done) state_next = (act_reg == ACT_REDUCE) ? ST_OUT : ST_B_GO;
            ST_B_GO:     state_next = ST_B_WAIT;
            ST_B_WAIT:   if (done) state_next = ST_EVAL;
            ST_EVAL:
            begin
                case (act_reg)
                    ACT_MUL: state_next = ST_FIN_GO;
                    ACT_DIV: state_next = (b_reg == 31'd0) ? ST_OUT : ST_POW_CHK;
                    ACT_POW: state_next = ST_POW_CHK;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_POW_CHK:
            begin
                if (e_reg == '0)
                    state_next = (act_reg == ACT_DIV) ? ST_FIN_GO : ST_OUT;
                else if (e_reg[0])
                    state_next = ST_ACC_GO;
                else
                    state_next = ST_SQ_GO;
            end
            ST_ACC_GO:   state_next = ST_ACC_WAIT;
            ST_ACC_WAIT: if (done) state_next = ST_SQ_GO;
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  if (done) state_next = ST_POW_CHK;
            ST_FIN_GO:   state_next = ST_FIN_WAIT;
            ST_FIN_WAIT: if (done) state_next = ST_OUT;
            ST_OUT:      if (out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        start     = 1'b0;
        mul_x     = a_reg;
        mul_y     = acc_reg;
        dividend  = {2'b0, product};
        case (state_reg)
            ST_A_GO:
            begin
                start = 1'b1;
                if (act_reg != ACT_REDUCE)
                    dividend = {33'd0, ra_reg};
                else if (sv_reg[63])
                    dividend = 64'd0 - sv_reg;
                else
                    dividend = sv_reg;
            end
            ST_B_GO:
            begin
                start    = 1'b1;
                dividend = {33'd0, rb_reg};
            end
            ST_ACC_GO:
            begin
                start = 1'b1;
                mul_x = acc_reg;
                mul_y = sq_reg;
            end
            ST_SQ_GO:
            begin
                start = 1'b1;
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
            ST_FIN_GO: start = 1'b1;
            default:   start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            modulus_reg <= MOD_RESET & MASK;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                modulus_reg <= cfg_data & MASK;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_reg <= in_data.action;
                    ra_reg  <= in_data.operand_a & MASK;
                    rb_reg  <= in_data.operand_b & MASK;
                    e_reg   <= in_data.exponent;
                    sv_reg  <= in_data.signed_value;
                    eq_reg  <= ((in_data.operand_a & MASK) == (in_data.operand_b & MASK));
                    m_reg   <= (modulus_reg < 31'd2) ? 31'd1 : modulus_reg;
                end
            end
            ST_A_WAIT:
            begin
                if (done)
                begin
                    a_reg <= rem;
                    // negative input folds back from the top
                    if (sv_reg[63] && rem != 31'd0)
                        result_reg <= m_reg - rem;
                    else
                        result_reg <= rem;
                end
            end
            ST_B_WAIT:
            begin
                if (done)
                    b_reg <= rem;
            end
            ST_EVAL:
            begin
                result_reg <= eval_val;
                acc_reg    <= (act_reg == ACT_MUL) ? b_reg : one_mod;
                case (act_reg)
                    ACT_DIV:
                    begin
                        sq_reg <= b_reg;
                        e_reg  <= {32'd0, m_reg - 31'd2};
                    end
                    ACT_POW: sq_reg <= a_reg;
                    default: sq_reg <= sq_reg;
                endcase
            end
            ST_POW_CHK:
            begin
                if (e_reg == '0)
                    result_reg <= acc_reg;
            end
            ST_ACC_WAIT:
            begin
                if (done)
                    acc_reg <= rem;
            end
            ST_SQ_WAIT:
            begin
                if (done)
                begin
                    sq_reg <= rem;
                    e_reg  <= {1'b0, e_reg[62:1]};
                end
            end
            ST_FIN_WAIT:
            begin
                if (done)
                    result_reg <= rem;
            end
            default: result_reg <= result_reg;
        endcase
    end

    assign out_data.result   = result_reg;
    assign out_data.is_equal = eq_reg;

endmodule

// ----- tb/modular_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// checks every operation of the modular unit against an in-bench predictor,
// over several moduli including the extremes, with bursty input and a
// receiver that stalls on its own pattern
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb;

    import mau_pkg::*;

    class mod_scoreboard;
        logic [30:0] modulus;
        mau_out_t    pending[$];
        int          errors;
        int          checked;

        function new();
            modulus = MOD_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                                    longint unsigned m);
            return (x * y) % m;
        endfunction

        function automatic longint unsigned pow_mod(longint unsigned base,
                                                    logic [62:0] e, longint unsigned m);
            longint unsigned acc;
            longint unsigned sq;
            acc = 1 % m;
            sq  = base % m;
            for (int i = 0; i < 63; i++)
            begin
                if (e[i])
                    acc = mul_mod(acc, sq, m);
                sq = mul_mod(sq, sq, m);
            end
            return acc;
        endfunction

        function automatic mau_out_t compute(mau_in_t req);
            longint unsigned m;
            longint unsigned a;
            longint unsigned b;
            longint unsigned r;
            longint unsigned mag;
            logic [63:0]     sv;
            mau_out_t        res;
            m  = (modulus < 2) ? 1 : modulus;
            a  = req.operand_a % m;
            b  = req.operand_b % m;
            sv = req.signed_value;
            r  = 0;
            case (req.action)
                ACT_REDUCE:
                begin
                    if (!sv[63])
                        r = sv % m;
                    else
                    begin
                        mag = (64'd0 - sv) % m;
                        r = (mag == 0) ? 0 : m - mag;
                    end
                end
                ACT_ADD:
                begin
                    r = a + b;
                    if (r >= m)
                        r -= m;
                end
                ACT_SUB:
                begin
                    r = a + (m - b);
                    if (r >= m)
                        r -= m;
                end
                ACT_MUL: r = mul_mod(a, b, m);
                ACT_DIV: r = (b == 0) ? 0 : mul_mod(a, pow_mod(b, 63'(m - 2), m), m);
                ACT_POW: r = pow_mod(a, req.exponent, m);
                ACT_NEG: r = (a == 0) ? 0 : m - a;
                default: r = 0;
            endcase
            res.result   = r[30:0];
            res.is_equal = (req.operand_a == req.operand_b);
            return res;
        endfunction

        function void note_request(mau_in_t req);
            pending.push_back(compute(req));
        endfunction

        function void check_result(mau_out_t got);
            mau_out_t want;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.result !== want.result)
            begin
                errors++;
                $display("%0t: result mismatch expected %0d actual %0d",
                         $time, want.result, got.result);
            end
            if (got.is_equal !== want.is_equal)
            begin
                errors++;
                $display("%0t: is_equal mismatch expected %0b actual %0b",
                         $time, want.is_equal, got.is_equal);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    mau_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    mau_out_t    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;

    mod_scoreboard sb;
    int            hold_cycles;
    int            burst_left;
    int            sent;
    int            phases;

    modular_arithmetic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

    // accepted requests, results and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (cfg_valid && cfg_ready)
                sb.modulus = cfg_data;
        end
    end

    // receiver stall pattern, in one of three modes picked at random
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(2);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (mode == 0)
                out_ready <= 1'b1;
            else if (mode == 1)
                out_ready <= $urandom_range(1);
            else
                out_ready <= ($urandom_range(3) == 0);
        end
    end

    task automatic send_request(mau_in_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(8, 1);
            gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_modulus(logic [30:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    function automatic logic [30:0] pick_operand(longint unsigned m);
        case ($urandom_range(9))
            0:       return 31'($urandom);
            1:       return 31'h7fffffff;
            2:       return 31'd0;
            3:       return 31'(m - 1);
            default: return 31'($urandom % m);
        endcase
    endfunction

    function automatic mau_in_t make_request(logic [30:0] modulus);
        mau_in_t         req;
        longint unsigned m;
        int              sel;
        m = (modulus < 2) ? 1 : modulus;
        req.operand_a    = pick_operand(m);
        req.operand_b    = ($urandom_range(7) == 0) ? req.operand_a : pick_operand(m);
        req.signed_value = {$urandom, $urandom};
        if ($urandom_range(5) == 0)
            req.signed_value = -64'(m * $urandom_range(1000));
        // long exponents are rare to keep the run short
        sel = $urandom_range(99);
        if (sel < 5)
            req.exponent = 63'({$urandom, $urandom});
        else if (sel < 15)
            req.exponent = 63'($urandom_range(20'hfffff));
        else
            req.exponent = 63'($urandom_range(255));
        sel = $urandom_range(99);
        if (sel < 18)      req.action = ACT_REDUCE;
        else if (sel < 34) req.action = ACT_ADD;
        else if (sel < 50) req.action = ACT_SUB;
        else if (sel < 66) req.action = ACT_MUL;
        else if (sel < 72) req.action = ACT_DIV;
        else if (sel < 86) req.action = ACT_POW;
        else if (sel < 98) req.action = ACT_NEG;
        else               req.action = 3'd7;
        return req;
    endfunction

    function automatic mau_in_t pack_request(logic [2:0] act, logic [30:0] a, logic [30:0] b,
                                             logic [62:0] e, logic [63:0] sv);
        mau_in_t req;
        req.action       = act;
        req.operand_a    = a;
        req.operand_b    = b;
        req.exponent     = e;
        req.signed_value = sv;
        return req;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_request(make_request(sb.modulus));
    endtask

    initial
    begin
        logic [30:0] mods[$];
        logic [30:0] m;
        sb = new();
        hold_cycles = 0;
        burst_left = 0;
        sent = 0;
        phases = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (5) @(negedge clk);

        // directed: reset modulus
        m = sb.modulus;
        send_request(pack_request(ACT_REDUCE, 0, 0, 0, 64'h8000000000000000));
        send_request(pack_request(ACT_REDUCE, 0, 0, 0, 64'h7fffffffffffffff));
        send_request(pack_request(ACT_REDUCE, 0, 0, 0, -64'(64'(m) * 12345)));
        send_request(pack_request(ACT_REDUCE, 0, 0, 0, 64'hffffffffffffffff));
        send_request(pack_request(ACT_REDUCE, 5, 5, 0, 0));
        send_request(pack_request(ACT_ADD, m - 31'd1, m - 31'd1, 0, 0));
        send_request(pack_request(ACT_ADD, 31'h7fffffff, 31'h7fffffff, 0, 0));
        send_request(pack_request(ACT_SUB, 0, m - 31'd1, 0, 0));
        send_request(pack_request(ACT_SUB, 31'h7fffffff, 0, 0, 0));
        send_request(pack_request(ACT_MUL, m - 31'd1, m - 31'd1, 0, 0));
        send_request(pack_request(ACT_MUL, 31'h7fffffff, 31'h7ffffffe, 0, 0));
        send_request(pack_request(ACT_DIV, 7, 0, 0, 0));
        send_request(pack_request(ACT_DIV, 7, m, 0, 0));
        send_request(pack_request(ACT_DIV, m - 31'd1, 3, 0, 0));
        send_request(pack_request(ACT_POW, 3, 0, 0, 0));
        send_request(pack_request(ACT_POW, 0, 0, 0, 0));
        send_request(pack_request(ACT_POW, 2, 1, 63'h7fffffffffffffff, 0));
        send_request(pack_request(ACT_POW, m - 31'd1, 0, 63'h5555555555555555, 0));
        send_request(pack_request(ACT_NEG, 0, 0, 0, 0));
        send_request(pack_request(ACT_NEG, 1, 2, 0, 0));
        send_request(pack_request(ACT_NEG, m, 0, 0, 0));
        send_request(pack_request(3'd7, 9, 9, 0, 64'h1));

        // long receiver hold-off while requests keep coming
        @(negedge clk);
        hold_cycles = 400;
        run_random(60);

        mods = '{31'h7fffffff, 31'd2, 31'd3, 31'd1000000007, 31'd65537,
                 31'd1, 31'd0, 31'd998244353};
        foreach (mods[i])
        begin
            write_modulus(mods[i]);
            run_random((mods[i] < 2) ? 40 : 90);
        end
        drain();

        $display("covered %0d requests over %0d modulus settings, all seven operations",
                 sent, phases + 1);
        $display("results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
